### hdl/bas_pkg.sv
// Shared types, codes and constants for the bridge ADC serial reader.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package bas_pkg;

    // Default converter word length in bits.
    localparam int DATA_BITS_DEF = 24;

    // Fixed widths of the result and configuration fields.
    localparam int READING_W    = 24;
    localparam int BATT_LIMIT_W = 23;
    localparam int SETUP_W      = 5;
    localparam int SETUP_MAX    = 31;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 4;

    // Sequencer phase of the serial readout.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } t_phase;

    // Request kinds, encoded as the action field.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PRESSURE,
        KIND_VOLTAGE,
        KIND_SETUP
    } t_kind;

    // Pressure classification codes.
    localparam logic [1:0] CLASS_HIGH   = 2'd0;
    localparam logic [1:0] CLASS_LOW    = 2'd1;
    localparam logic [1:0] CLASS_NORMAL = 2'd2;

    // Configuration register indexes (byte address divided by four).
    localparam logic [1:0] REG_PRESS_HIGH = 2'd0;
    localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
    localparam logic [1:0] REG_BATT_LOW   = 2'd2;
    localparam logic [1:0] REG_SETUP_CNT  = 2'd3;

    // Configuration register reset values.
    localparam logic [READING_W-1:0]    PRESS_HIGH_RST = 24'hFF_FFFF;
    localparam logic [READING_W-1:0]    PRESS_LOW_RST  = 24'h00_0000;
    localparam logic [BATT_LIMIT_W-1:0] BATT_LOW_RST   = 23'h00_0000;
    localparam logic [SETUP_W-1:0]      SETUP_CNT_RST  = 5'd25;

    typedef struct packed {
        logic [READING_W-1:0]    press_high_limit;
        logic [READING_W-1:0]    press_low_limit;
        logic [BATT_LIMIT_W-1:0] batt_low_limit;
        logic [SETUP_W-1:0]      setup_pulse_count;
    } t_cfg;

    typedef struct packed {
        logic                 clock_level;
        logic                 busy_res;
        logic                 done_res;
        logic [READING_W-1:0] reading;
        logic [1:0]           pressure_class;
        logic                 battery_low;
    } t_result;

endpackage

`default_nettype wire

### hdl/bas_if.sv
// Valid/ready channel interfaces for the request ticks and the results.
// Depends on bas_pkg for the field widths.
`default_nettype none

interface bas_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       data_line;

    modport source (output valid, output action, output data_line, input ready);
    modport sink   (input valid, input action, input data_line, output ready);
endinterface

interface bas_out_if;
    logic                           valid;
    logic                           ready;
    logic                           clock_level;
    logic                           busy_res;
    logic                           done_res;
    logic [bas_pkg::READING_W-1:0]  reading;
    logic [1:0]                     pressure_class;
    logic                           battery_low;

    modport source (output valid, output clock_level, output busy_res, output done_res,
                    output reading, output pressure_class, output battery_low,
                    input ready);
    modport sink   (input valid, input clock_level, input busy_res, input done_res,
                    input reading, input pressure_class, input battery_low,
                    output ready);
endinterface

`default_nettype wire

### hdl/bas_cfg.sv
// APB-style configuration registers for the bridge ADC serial reader.
// Depends on bas_pkg for register indexes, widths and reset values.
`default_nettype none

module bas_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bas_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bas_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bas_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output bas_pkg::t_cfg                       o_cfg
);

    bas_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_high_limit  <= bas_pkg::PRESS_HIGH_RST;
            r_cfg.press_low_limit   <= bas_pkg::PRESS_LOW_RST;
            r_cfg.batt_low_limit    <= bas_pkg::BATT_LOW_RST;
            r_cfg.setup_pulse_count <= bas_pkg::SETUP_CNT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                bas_pkg::REG_PRESS_HIGH: begin
                    r_cfg.press_high_limit <= pwdata[bas_pkg::READING_W-1:0];
                end
                bas_pkg::REG_PRESS_LOW: begin
                    r_cfg.press_low_limit <= pwdata[bas_pkg::READING_W-1:0];
                end
                bas_pkg::REG_BATT_LOW: begin
                    r_cfg.batt_low_limit <= pwdata[bas_pkg::BATT_LIMIT_W-1:0];
                end
                bas_pkg::REG_SETUP_CNT: begin
                    r_cfg.setup_pulse_count <= pwdata[bas_pkg::SETUP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bas_pkg::REG_PRESS_HIGH: prdata = bas_pkg::APB_DATA_W'(r_cfg.press_high_limit);
            bas_pkg::REG_PRESS_LOW:  prdata = bas_pkg::APB_DATA_W'(r_cfg.press_low_limit);
            bas_pkg::REG_BATT_LOW:   prdata = bas_pkg::APB_DATA_W'(r_cfg.batt_low_limit);
            bas_pkg::REG_SETUP_CNT:  prdata = bas_pkg::APB_DATA_W'(r_cfg.setup_pulse_count);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hdl/bas_core.sv
// Readout sequencer: phase state machine, pulse counter, shift register and
// result classification for one tick. Depends on bas_pkg.
`default_nettype none

module bas_core #(
    parameter int DATA_BITS = bas_pkg::DATA_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire logic [1:0] i_action,
    input  wire logic       i_data_line,
    input  wire bas_pkg::t_cfg i_cfg,
    output bas_pkg::t_result o_res
);

    // The counter must hold the longest read and the largest set-up count.
    localparam int MaxPulses = ((DATA_BITS + 2) > bas_pkg::SETUP_MAX) ?
                               (DATA_BITS + 2) : bas_pkg::SETUP_MAX;
    localparam int PW = $clog2(MaxPulses + 1);
    // Compare width covers both the word and the 24-bit limits.
    localparam int CW = (DATA_BITS > bas_pkg::READING_W) ? DATA_BITS : bas_pkg::READING_W;
    localparam logic [DATA_BITS-1:0] WordMsb = {1'b1, {(DATA_BITS-1){1'b0}}};

    bas_pkg::t_phase       r_phase, n_phase;
    bas_pkg::t_kind        r_kind, n_kind;
    logic [PW-1:0]         r_pidx, n_pidx;
    logic [DATA_BITS-1:0]  r_shift, n_shift;

    bas_pkg::t_phase       ph;
    bas_pkg::t_kind        kind;
    logic [PW-1:0]         pidx;
    logic [DATA_BITS-1:0]  shift;
    logic [PW-1:0]         total;
    logic                  finish;
    logic                  clk_lvl;
    logic [DATA_BITS-1:0]  word;
    logic [CW-1:0]         word_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bas_pkg::PH_IDLE;
            r_kind  <= bas_pkg::KIND_NONE;
            r_pidx  <= '0;
            r_shift <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_pidx  <= n_pidx;
            r_shift <= n_shift;
        end
    end

    always_comb begin
        // A request taken in idle also counts as the first wait tick.
        ph    = r_phase;
        kind  = r_kind;
        pidx  = r_pidx;
        shift = r_shift;
        if (r_phase == bas_pkg::PH_IDLE && bas_pkg::t_kind'(i_action) != bas_pkg::KIND_NONE) begin
            kind  = bas_pkg::t_kind'(i_action);
            pidx  = '0;
            shift = '0;
            ph    = bas_pkg::PH_WAIT;
        end

        unique case (kind)
            bas_pkg::KIND_PRESSURE: total = PW'(DATA_BITS + 2);
            bas_pkg::KIND_VOLTAGE:  total = PW'(DATA_BITS + 1);
            default:                total = PW'(i_cfg.setup_pulse_count);
        endcase

        n_phase = ph;
        n_kind  = kind;
        n_pidx  = pidx;
        n_shift = shift;
        finish  = 1'b0;
        clk_lvl = 1'b0;

        unique case (ph)
            bas_pkg::PH_IDLE: begin
            end
            bas_pkg::PH_WAIT: begin
                if (!i_data_line) begin
                    if (total == '0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = bas_pkg::PH_HIGH;
                    end
                end
            end
            bas_pkg::PH_HIGH: begin
                clk_lvl = 1'b1;
                n_phase = bas_pkg::PH_LOW;
            end
            bas_pkg::PH_LOW: begin
                // Data bits are sampled after the falling edge of the first pulses.
                if (pidx < PW'(DATA_BITS) && kind != bas_pkg::KIND_SETUP) begin
                    n_shift = {shift[DATA_BITS-2:0], i_data_line};
                end
                n_pidx = pidx + PW'(1);
                if (n_pidx >= total) begin
                    finish = 1'b1;
                end else begin
                    n_phase = bas_pkg::PH_HIGH;
                end
            end
            default: begin
            end
        endcase

        if (finish) begin
            n_phase = bas_pkg::PH_IDLE;
        end

        // Pressure words are offset binary; voltage words drop the sign bit.
        if (kind == bas_pkg::KIND_PRESSURE) begin
            word = n_shift ^ WordMsb;
        end else begin
            word = n_shift & ~WordMsb;
        end
        word_ext = CW'(word);

        o_res.clock_level    = clk_lvl;
        o_res.busy_res       = (n_phase != bas_pkg::PH_IDLE);
        o_res.done_res       = finish;
        o_res.reading        = '0;
        o_res.pressure_class = bas_pkg::CLASS_NORMAL;
        o_res.battery_low    = 1'b0;

        if (finish && kind == bas_pkg::KIND_PRESSURE) begin
            o_res.reading = word_ext[bas_pkg::READING_W-1:0];
            if (word_ext >= CW'(i_cfg.press_high_limit)) begin
                o_res.pressure_class = bas_pkg::CLASS_HIGH;
            end else if (word_ext <= CW'(i_cfg.press_low_limit)) begin
                o_res.pressure_class = bas_pkg::CLASS_LOW;
            end
        end else if (finish && kind == bas_pkg::KIND_VOLTAGE) begin
            o_res.reading     = word_ext[bas_pkg::READING_W-1:0];
            o_res.battery_low = (word_ext <= CW'(i_cfg.batt_low_limit));
        end
    end

    // A finished request always leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_res.done_res |=> r_phase == bas_pkg::PH_IDLE)
        else $error("sequencer not idle after a finished request");

    // A high clock tick is always followed by the low half of the pulse.
    a_high_then_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && o_res.clock_level |=> r_phase == bas_pkg::PH_LOW)
        else $error("clock high tick not followed by low phase");

    // State only moves when a tick is processed.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_phase) && $stable(r_pidx) && $stable(r_shift))
        else $error("sequencer state changed without a tick");

    // The pulse counter never runs past the longest request.
    a_pidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pidx <= PW'(MaxPulses))
        else $error("pulse counter out of range");

endmodule

`default_nettype wire

### hdl/bridge_adc_serial_reader_top.sv
// Top level of the bridge ADC serial reader: input register, sequencer,
// result register and configuration port. Depends on bas_pkg, bas_if,
// bas_cfg and bas_core.
//
// Usage: each transfer on the request channel (i_in_ch) is one half-period
// tick of the converter serial clock. It carries the sampled data line level
// and, while the block is idle, a request: pressure read, voltage read or
// mode set-up. For every tick exactly one result transfer leaves on o_res_ch,
// giving the clock level to drive during that tick, the busy flag, and on
// the tick a request finishes the done flag, the reading and its class.
// A tick is held in an input register and processed into a result register
// by one pass of short logic, and the block sustains one tick per clock
// cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transfer and the
// input register absorbs one more tick; the request channel then deasserts
// ready until the result is taken, so nothing is lost or repeated.
// Reset (synchronous, active low) empties both registers, returns the
// sequencer to idle and loads the configuration registers with their
// defaults: high limit all ones, low limits zero, 25 set-up pulses.
// The APB port is always ready; registers lie at byte addresses 0, 4, 8 and
// 12 and should be written only while no request is in flight.
`default_nettype none

module bridge_adc_serial_reader_top #(
    parameter int DATA_BITS = bas_pkg::DATA_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bas_in_if.sink                              i_in_ch,
    bas_out_if.source                           o_res_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bas_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bas_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bas_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    bas_pkg::t_cfg    cfg;
    bas_pkg::t_result res;

    // Input register holding one accepted tick.
    logic       r_in_valid;
    logic [1:0] r_in_action;
    logic       r_in_data;

    // Result register facing the receiver.
    logic             r_out_valid;
    bas_pkg::t_result r_out;

    logic adv;
    logic in_xfer;

    // A tick is processed when the result register is free or being emptied.
    assign adv     = r_in_valid && (!r_out_valid || o_res_ch.ready);
    assign i_in_ch.ready = !r_in_valid || adv;
    assign in_xfer = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_action <= i_in_ch.action;
            r_in_data   <= i_in_ch.data_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    bas_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bas_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_action    (r_in_action),
        .i_data_line (r_in_data),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    assign o_res_ch.valid          = r_out_valid;
    assign o_res_ch.clock_level    = r_out.clock_level;
    assign o_res_ch.busy_res       = r_out.busy_res;
    assign o_res_ch.done_res       = r_out.done_res;
    assign o_res_ch.reading        = r_out.reading;
    assign o_res_ch.pressure_class = r_out.pressure_class;
    assign o_res_ch.battery_low    = r_out.battery_low;

    // A held tick that cannot advance stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_action) && $stable(r_in_data))
        else $error("pending tick lost from input register");

    // Every processed tick shows up in the result register.
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("processed tick did not produce a result");

    // No tick is processed while a stalled result still occupies the output.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res_ch.ready |-> !adv)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
